/* src/tafp_pkg.sv */
// Types, codes and constants shared by the adaptation field parser modules.
package tafp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_FLAGS    = 4'd1,
    PH_PCR      = 4'd2,
    PH_OPCR     = 4'd3,
    PH_SPLICE   = 4'd4,
    PH_PRIVLEN  = 4'd5,
    PH_PRIVSKIP = 4'd6,
    PH_EXTLEN   = 4'd7,
    PH_EXTFLAGS = 4'd8,
    PH_LTW      = 4'd9,
    PH_RATE     = 4'd10,
    PH_SEAMLESS = 4'd11,
    PH_STUFF    = 4'd12,
    PH_DONE     = 4'd13
  } phase_e;

  typedef enum logic [3:0] {
    KIND_LENGTH    = 4'd0,
    KIND_FLAGS     = 4'd1,
    KIND_PCR       = 4'd2,
    KIND_OPCR      = 4'd3,
    KIND_SPLICE    = 4'd4,
    KIND_PRIVLEN   = 4'd5,
    KIND_EXTLEN    = 4'd6,
    KIND_EXTFLAGS  = 4'd7,
    KIND_LTW       = 4'd8,
    KIND_RATE      = 4'd9,
    KIND_SEAMLESS  = 4'd10,
    KIND_END       = 4'd11,
    KIND_ERROR     = 4'd12
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_ZERO_LEN  = 4'd1,
    ERR_PCR       = 4'd2,
    ERR_OPCR      = 4'd3,
    ERR_SPLICE    = 4'd4,
    ERR_PRIVATE   = 4'd5,
    ERR_EXT_LONG  = 4'd6,
    ERR_EXT_FLAGS = 4'd7,
    ERR_LTW       = 4'd8,
    ERR_RATE      = 4'd9,
    ERR_SEAMLESS  = 4'd10
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [32:0] main;
    logic [8:0]  extra;
    err_e        err;
    logic        last;
  } res_t;

  // Results caused by one accepted byte.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } emit_t;

  localparam logic [2:0] NEED_PCR      = 3'd6;
  localparam logic [2:0] NEED_SPLICE   = 3'd1;
  localparam logic [2:0] NEED_LTW      = 3'd2;
  localparam logic [2:0] NEED_RATE     = 3'd3;
  localparam logic [2:0] NEED_SEAMLESS = 3'd5;

  // floor(y/45) = (y * 11651) >> 19 for y < 74898
  localparam logic [13:0] DIV45_RECIP = 14'd11651;
  localparam int unsigned DIV45_SHIFT = 19;
  localparam logic [14:0] DTS_DIVISOR = 15'd90;
  localparam logic [6:0]  DTS_HALF    = 7'd45;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  function automatic res_t mk_res(kind_e kind, logic [32:0] main, logic [8:0] extra,
                                  err_e err);
    res_t r;
    r.kind  = kind;
    r.main  = main;
    r.extra = extra;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

/* src/tafp_core.sv */
// Byte-wise parse state and result generation for one adaptation field byte.
module tafp_core import tafp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_field_i,
  output emit_t      emit_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  fbl_q, fbl_d;
  logic [7:0]  ebl_q, ebl_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [4:0]  pm_q, pm_d;
  logic [2:0]  pe_q, pe_d;
  logic [47:0] shift_q, shift_d;
  logic [7:0]  skip_q, skip_d;
  logic [26:0] quot_q, quot_d;
  logic [6:0]  rem_q, rem_d;

  logic [7:0]  b;
  logic [7:0]  fbl_dec, ebl_dec, skip_dec;
  logic        is_ext_elem;
  logic [4:0]  pm_post;
  logic [2:0]  pe_post;
  logic [7:0]  ebl_post;

  // advance decision
  phase_e      adv_phase;
  logic [4:0]  adv_pm;
  logic [2:0]  adv_pe;
  err_e        adv_err;
  logic        adv_end;
  logic        adv_sel;
  logic [7:0]  adv_have;
  logic [2:0]  adv_need;
  err_e        adv_code;
  phase_e      adv_next;

  // element assembly
  logic [2:0]  cnt_inc;
  logic [2:0]  need_cur;
  logic        elem_done;
  logic [47:0] shift_nx;

  // DTS division by 90, one chunk per byte
  logic [14:0] div_x;
  logic [27:0] div_prod;
  logic [7:0]  div_q;
  logic [14:0] div_r_full;
  logic [6:0]  div_r;
  logic [26:0] quot_sh;
  logic [32:0] dts_ms;

  logic        priv_fail, ext_fail;
  logic        prim_v, sec_v;
  res_t        prim, sec, elem_res, adv_res;
  logic        adv_emits;

  assign b           = data_byte_i;
  assign fbl_dec     = fbl_q - 8'd1;
  assign ebl_dec     = ebl_q - 8'd1;
  assign skip_dec    = skip_q - 8'd1;
  assign is_ext_elem = (phase_q == PH_LTW) || (phase_q == PH_RATE) || (phase_q == PH_SEAMLESS);
  assign pm_post     = (phase_q == PH_FLAGS) ? b[4:0] : pm_q;
  assign pe_post     = (phase_q == PH_EXTFLAGS) ? b[7:5] : pe_q;
  assign ebl_post    = (is_ext_elem || (phase_q == PH_EXTFLAGS)) ? ebl_dec : ebl_q;

  assign priv_fail = {1'b0, fbl_q} < (9'd1 + {1'b0, b});
  assign ext_fail  = ({1'b0, b} + 9'd1) > {1'b0, fbl_q};

  // Pick the next element from the pending flags, extension flags first.
  always_comb begin
    adv_pm   = pm_post;
    adv_pe   = pe_post;
    adv_sel  = 1'b1;
    adv_have = fbl_dec;
    adv_need = NEED_SPLICE;
    adv_code = ERR_NONE;
    adv_next = PH_STUFF;
    if (pe_post[2]) begin
      adv_pe = {1'b0, pe_post[1:0]};
      adv_have = ebl_post; adv_need = NEED_LTW; adv_code = ERR_LTW; adv_next = PH_LTW;
    end else if (pe_post[1]) begin
      adv_pe = {2'b00, pe_post[0]};
      adv_have = ebl_post; adv_need = NEED_RATE; adv_code = ERR_RATE; adv_next = PH_RATE;
    end else if (pe_post[0]) begin
      adv_pe = 3'd0;
      adv_have = ebl_post; adv_need = NEED_SEAMLESS; adv_code = ERR_SEAMLESS;
      adv_next = PH_SEAMLESS;
    end else if (pm_post[4]) begin
      adv_pm = {1'b0, pm_post[3:0]};
      adv_need = NEED_PCR; adv_code = ERR_PCR; adv_next = PH_PCR;
    end else if (pm_post[3]) begin
      adv_pm = {2'b00, pm_post[2:0]};
      adv_need = NEED_PCR; adv_code = ERR_OPCR; adv_next = PH_OPCR;
    end else if (pm_post[2]) begin
      adv_pm = {3'b000, pm_post[1:0]};
      adv_code = ERR_SPLICE; adv_next = PH_SPLICE;
    end else if (pm_post[1]) begin
      adv_pm = {4'b0000, pm_post[0]};
      adv_code = ERR_PRIVATE; adv_next = PH_PRIVLEN;
    end else if (pm_post[0]) begin
      adv_pm = 5'd0;
      adv_code = ERR_EXT_LONG; adv_next = PH_EXTLEN;
    end else begin
      adv_sel = 1'b0;
    end

    adv_err   = ERR_NONE;
    adv_end   = 1'b0;
    adv_phase = adv_next;
    if (adv_sel) begin
      if (adv_have < {5'd0, adv_need}) begin
        adv_phase = PH_DONE;
        adv_err   = adv_code;
      end
    end else if (fbl_dec == 8'd0) begin
      adv_phase = PH_DONE;
      adv_end   = 1'b1;
    end else begin
      adv_phase = PH_STUFF;
    end
  end

  assign cnt_inc  = cnt_q + 3'd1;
  assign shift_nx = {shift_q[39:0], b};

  always_comb begin
    case (phase_q)
      PH_LTW:      need_cur = NEED_LTW;
      PH_RATE:     need_cur = NEED_RATE;
      PH_SEAMLESS: need_cur = NEED_SEAMLESS;
      default:     need_cur = NEED_PCR;
    endcase
  end
  assign elem_done = cnt_inc >= need_cur;

  // DTS bits arrive as 3, 8, 7, 8, 7 bits; long division carries a remainder below 90.
  always_comb begin
    case (cnt_q)
      3'd0:    div_x = {12'd0, b[3:1]};
      3'd1:    div_x = {rem_q, b};
      3'd2:    div_x = {1'b0, rem_q, b[7:1]};
      3'd3:    div_x = {rem_q, b};
      3'd4:    div_x = {1'b0, rem_q, b[7:1]};
      default: div_x = 15'd0;
    endcase
  end

  assign div_prod   = 28'(div_x[14:1]) * 28'(DIV45_RECIP);
  assign div_q      = div_prod[DIV45_SHIFT +: 8];
  assign div_r_full = div_x - 15'(15'(div_q) * DTS_DIVISOR);
  assign div_r      = div_r_full[6:0];

  always_comb begin
    case (cnt_q)
      3'd1, 3'd3: quot_sh = {quot_q[18:0], div_q};
      3'd2, 3'd4: quot_sh = {quot_q[19:0], div_q[6:0]};
      default:    quot_sh = 27'(div_q);
    endcase
  end

  assign dts_ms = 33'(quot_sh) + 33'(div_r >= DTS_HALF);

  // Next state
  always_comb begin
    phase_d = phase_q;
    fbl_d   = fbl_q;
    ebl_d   = ebl_q;
    cnt_d   = cnt_q;
    pm_d    = pm_q;
    pe_d    = pe_q;
    shift_d = shift_q;
    skip_d  = skip_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    if (step_i) begin
      if (start_of_field_i) begin
        ebl_d   = 8'd0;
        cnt_d   = 3'd0;
        pm_d    = 5'd0;
        pe_d    = 3'd0;
        shift_d = 48'd0;
        skip_d  = 8'd0;
        if (b == 8'd0) begin
          fbl_d   = 8'd0;
          phase_d = PH_DONE;
        end else begin
          fbl_d   = b;
          phase_d = PH_FLAGS;
        end
      end else begin
        case (phase_q)
          PH_FLAGS, PH_SPLICE, PH_EXTFLAGS: begin
            fbl_d   = fbl_dec;
            ebl_d   = ebl_post;
            phase_d = adv_phase;
            pm_d    = adv_pm;
            pe_d    = adv_pe;
            cnt_d   = 3'd0;
            shift_d = 48'd0;
          end
          PH_PCR, PH_OPCR, PH_LTW, PH_RATE, PH_SEAMLESS: begin
            fbl_d   = fbl_dec;
            ebl_d   = ebl_post;
            cnt_d   = cnt_inc;
            shift_d = shift_nx;
            if (phase_q == PH_SEAMLESS) begin
              quot_d = quot_sh;
              rem_d  = div_r;
            end
            if (elem_done) begin
              phase_d = adv_phase;
              pm_d    = adv_pm;
              pe_d    = adv_pe;
              cnt_d   = 3'd0;
              shift_d = 48'd0;
            end
          end
          PH_PRIVLEN: begin
            if (priv_fail) begin
              phase_d = PH_DONE;
            end else begin
              fbl_d  = fbl_dec;
              skip_d = b;
              if (b != 8'd0) begin
                phase_d = PH_PRIVSKIP;
              end else begin
                phase_d = adv_phase;
                pm_d    = adv_pm;
                pe_d    = adv_pe;
                cnt_d   = 3'd0;
                shift_d = 48'd0;
              end
            end
          end
          PH_PRIVSKIP: begin
            fbl_d  = fbl_dec;
            skip_d = skip_dec;
            if (skip_dec == 8'd0) begin
              phase_d = adv_phase;
              pm_d    = adv_pm;
              pe_d    = adv_pe;
              cnt_d   = 3'd0;
              shift_d = 48'd0;
            end
          end
          PH_EXTLEN: begin
            if (ext_fail) begin
              phase_d = PH_DONE;
            end else begin
              fbl_d = fbl_dec;
              if (b == 8'd0) begin
                phase_d = PH_DONE;
              end else begin
                ebl_d   = b;
                phase_d = PH_EXTFLAGS;
              end
            end
          end
          PH_STUFF: begin
            fbl_d = fbl_dec;
            if (fbl_dec == 8'd0) begin
              phase_d = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Outputs
  always_comb begin
    case (phase_q)
      PH_PCR:      elem_res = mk_res(KIND_PCR, shift_nx[47:15], shift_nx[8:0], ERR_NONE);
      PH_OPCR:     elem_res = mk_res(KIND_OPCR, shift_nx[47:15], shift_nx[8:0], ERR_NONE);
      PH_LTW:      elem_res = mk_res(KIND_LTW, 33'(shift_nx[14:0]), 9'(shift_nx[15]),
                                     ERR_NONE);
      PH_RATE:     elem_res = mk_res(KIND_RATE, 33'(shift_nx[21:0]), 9'd0, ERR_NONE);
      default:     elem_res = mk_res(KIND_SEAMLESS, dts_ms, 9'(shift_nx[39:36]), ERR_NONE);
    endcase
  end

  assign adv_emits = (adv_err != ERR_NONE) || adv_end;
  assign adv_res   = (adv_err != ERR_NONE) ? mk_res(KIND_ERROR, 33'd0, 9'd0, adv_err)
                                           : mk_res(KIND_END, 33'd0, 9'd0, ERR_NONE);

  always_comb begin
    prim_v = 1'b0;
    sec_v  = 1'b0;
    prim   = mk_res(KIND_END, 33'd0, 9'd0, ERR_NONE);
    sec    = adv_res;
    if (step_i) begin
      if (start_of_field_i) begin
        prim_v = 1'b1;
        if (b == 8'd0) begin
          prim = mk_res(KIND_ERROR, 33'd0, 9'd0, ERR_ZERO_LEN);
        end else begin
          prim = mk_res(KIND_LENGTH, 33'(b), 9'd0, ERR_NONE);
        end
      end else begin
        case (phase_q)
          PH_FLAGS: begin
            prim_v = 1'b1;
            prim   = mk_res(KIND_FLAGS, 33'(b), 9'd0, ERR_NONE);
            sec_v  = adv_emits;
          end
          PH_SPLICE: begin
            prim_v = 1'b1;
            prim   = mk_res(KIND_SPLICE, 33'(b), 9'd0, ERR_NONE);
            sec_v  = adv_emits;
          end
          PH_EXTFLAGS: begin
            prim_v = 1'b1;
            prim   = mk_res(KIND_EXTFLAGS, 33'(b), 9'd0, ERR_NONE);
            sec_v  = adv_emits;
          end
          PH_PCR, PH_OPCR, PH_LTW, PH_RATE, PH_SEAMLESS: begin
            prim_v = elem_done;
            prim   = elem_res;
            sec_v  = elem_done && adv_emits;
          end
          PH_PRIVLEN: begin
            prim_v = 1'b1;
            if (priv_fail) begin
              prim = mk_res(KIND_ERROR, 33'd0, 9'd0, ERR_PRIVATE);
            end else begin
              prim  = mk_res(KIND_PRIVLEN, 33'(b), 9'd0, ERR_NONE);
              sec_v = (b == 8'd0) && adv_emits;
            end
          end
          PH_PRIVSKIP: begin
            sec_v = (skip_dec == 8'd0) && adv_emits;
          end
          PH_EXTLEN: begin
            prim_v = 1'b1;
            if (ext_fail) begin
              prim = mk_res(KIND_ERROR, 33'd0, 9'd0, ERR_EXT_LONG);
            end else begin
              prim  = mk_res(KIND_EXTLEN, 33'(b), 9'd0, ERR_NONE);
              sec_v = (b == 8'd0);
              sec   = mk_res(KIND_ERROR, 33'd0, 9'd0, ERR_EXT_FLAGS);
            end
          end
          PH_STUFF: begin
            sec_v = (fbl_dec == 8'd0);
            sec   = mk_res(KIND_END, 33'd0, 9'd0, ERR_NONE);
          end
          default: begin
          end
        endcase
      end
    end

    emit_o.r0 = prim_v ? prim : sec;
    emit_o.r1 = sec;
    if (prim_v && sec_v) begin
      emit_o.cnt     = 2'd2;
      emit_o.r1.last = 1'b1;
    end else if (prim_v || sec_v) begin
      emit_o.cnt     = 2'd1;
      emit_o.r0.last = 1'b1;
    end else begin
      emit_o.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fbl_q   <= 8'd0;
      ebl_q   <= 8'd0;
      cnt_q   <= 3'd0;
      pm_q    <= 5'd0;
      pe_q    <= 3'd0;
      skip_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      fbl_q   <= fbl_d;
      ebl_q   <= ebl_d;
      cnt_q   <= cnt_d;
      pm_q    <= pm_d;
      pe_q    <= pe_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    quot_q  <= quot_d;
    rem_q   <= rem_d;
  end

endmodule

/* src/tafp_res_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one.
module tafp_res_fifo import tafp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  emit_t emit_i,
  input  logic  pop_i,
  output logic  space_o,
  output logic  valid_o,
  output res_t  head_o
);

  res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic [FIFO_AW-1:0] wr_nx;

  assign wr_nx   = wr_q + FIFO_AW'(1);
  assign valid_o = cnt_q != '0;
  assign space_o = cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (emit_i.cnt != 2'd0) begin
      mem_q[wr_q] <= emit_i.r0;
    end
    if (emit_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= emit_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FIFO_AW'(emit_i.cnt);
      rd_q  <= rd_q + FIFO_AW'(pop_i);
      cnt_q <= cnt_q + (FIFO_AW+1)'(emit_i.cnt) - (FIFO_AW+1)'(pop_i);
    end
  end

endmodule

/* src/ts_adaptation_field_parser_top.sv */
// Top level of the transport stream adaptation field parser.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | data_byte_i, start_of_field_i
//   out     | output    | out_valid_o/out_ready_i| item_kind_o, main_value_o,
//           |           |                        | extra_value_o, error_code_o, last_result_o
//
// One byte per cycle is parsed on acceptance; its zero to two results enter a
// four-entry result queue and leave at one per cycle while out_ready_i is high.
// in_ready_o is high while at least two queue entries are free.
// Reset leaves the parser idle until a byte marked start_of_field_i.
// Output stalls only fill the queue; fewer than two free entries hold off input bytes.
module ts_adaptation_field_parser_top import tafp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_field_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  item_kind_o,
  output logic [32:0] main_value_o,
  output logic [8:0]  extra_value_o,
  output logic [3:0]  error_code_o,
  output logic        last_result_o
);

  emit_t emit;
  res_t  head;
  logic  step;

  assign step = in_valid_i && in_ready_o;

  tafp_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .data_byte_i      (data_byte_i),
    .start_of_field_i (start_of_field_i),
    .emit_o           (emit)
  );

  tafp_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .pop_i   (out_valid_o && out_ready_i),
    .space_o (in_ready_o),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign item_kind_o   = head.kind;
  assign main_value_o  = head.main;
  assign extra_value_o = head.extra;
  assign error_code_o  = head.err;
  assign last_result_o = head.last;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the transport stream adaptation field parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tafp_pkg::*;

  localparam logic [63:0] DTS_ROUND     = 64'd45;
  localparam logic [63:0] DTS_PER_MS    = 64'd90;
  localparam int unsigned RANDOM_BYTES  = 600;
  localparam int unsigned DRAIN_LIMIT   = 5000;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_e;
  typedef enum int {DMG_SHORT_LEN, DMG_EXT_LEN, DMG_PRIV_LEN, DMG_LONG_LEN, DMG_TRUNCATE} damage_e;

  class field_scoreboard;
    res_t        expected_q[$];
    res_t        staged[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_bytes;
    int unsigned n_starts;
    int unsigned kind_hits[16];

    phase_e      phase;
    logic [7:0]  fb_left;
    logic [7:0]  ext_left;
    logic [7:0]  skip;
    logic [2:0]  elem_cnt;
    logic [4:0]  main_pend;
    logic [2:0]  ext_pend;
    logic [47:0] shift;
    bit          err_latched;

    function new();
      clear();
    endfunction

    function void clear();
      phase       = PH_IDLE;
      fb_left     = '0;
      ext_left    = '0;
      skip        = '0;
      elem_cnt    = '0;
      main_pend   = '0;
      ext_pend    = '0;
      shift       = '0;
      err_latched = 1'b0;
    endfunction

    function void emit(kind_e k, logic [32:0] m, logic [8:0] x, err_e e);
      res_t r;
      if (staged.size() >= 2) return;
      r.kind  = k;
      r.main  = m;
      r.extra = x;
      r.err   = e;
      r.last  = 1'b0;
      staged.push_back(r);
    endfunction

    function void fail(err_e code);
      emit(KIND_ERROR, '0, '0, code);
      err_latched = 1'b1;
      phase       = PH_DONE;
    endfunction

    function void start_elem(int have, int need, err_e code, phase_e ph);
      if (have < need) begin
        fail(code);
        return;
      end
      phase    = ph;
      elem_cnt = '0;
      shift    = '0;
    endfunction

    function void advance();
      if (ext_pend[2]) begin
        ext_pend[2] = 1'b0;
        start_elem(ext_left, NEED_LTW, ERR_LTW, PH_LTW);
      end else if (ext_pend[1]) begin
        ext_pend[1] = 1'b0;
        start_elem(ext_left, NEED_RATE, ERR_RATE, PH_RATE);
      end else if (ext_pend[0]) begin
        ext_pend[0] = 1'b0;
        start_elem(ext_left, NEED_SEAMLESS, ERR_SEAMLESS, PH_SEAMLESS);
      end else if (main_pend[4]) begin
        main_pend[4] = 1'b0;
        start_elem(fb_left, NEED_PCR, ERR_PCR, PH_PCR);
      end else if (main_pend[3]) begin
        main_pend[3] = 1'b0;
        start_elem(fb_left, NEED_PCR, ERR_OPCR, PH_OPCR);
      end else if (main_pend[2]) begin
        main_pend[2] = 1'b0;
        start_elem(fb_left, NEED_SPLICE, ERR_SPLICE, PH_SPLICE);
      end else if (main_pend[1]) begin
        main_pend[1] = 1'b0;
        start_elem(fb_left, 1, ERR_PRIVATE, PH_PRIVLEN);
      end else if (main_pend[0]) begin
        main_pend[0] = 1'b0;
        start_elem(fb_left, 1, ERR_EXT_LONG, PH_EXTLEN);
      end else if (fb_left == 8'd0) begin
        emit(KIND_END, '0, '0, ERR_NONE);
        phase = PH_DONE;
      end else begin
        phase = PH_STUFF;
      end
    endfunction

    function void finish_elem();
      logic [47:0] a;
      logic [7:0]  b0, b1, b2, b3, b4;
      logic [63:0] dts;
      logic [63:0] ms;
      a  = shift;
      b0 = a[39:32];
      b1 = a[31:24];
      b2 = a[23:16];
      b3 = a[15:8];
      b4 = a[7:0];
      case (phase)
        PH_PCR:  emit(KIND_PCR, a[47:15], a[8:0], ERR_NONE);
        PH_OPCR: emit(KIND_OPCR, a[47:15], a[8:0], ERR_NONE);
        PH_LTW:  emit(KIND_LTW, {18'd0, a[14:0]}, {8'd0, a[15]}, ERR_NONE);
        PH_RATE: emit(KIND_RATE, {11'd0, a[21:0]}, 9'd0, ERR_NONE);
        default: begin
          dts = {31'd0, b0[3:1], b1, b2[7:1], b3, b4[7:1]};
          ms  = (dts + DTS_ROUND) / DTS_PER_MS;
          emit(KIND_SEAMLESS, ms[32:0], {5'd0, b0[7:4]}, ERR_NONE);
        end
      endcase
      advance();
    endfunction

    // Runs the parser model on one accepted byte and queues what it yields.
    function void note_byte(logic [7:0] b, logic sof);
      int   need;
      res_t r;
      staged.delete();
      n_bytes++;
      if (sof) begin
        n_starts++;
        clear();
        if (b == 8'd0) begin
          fail(ERR_ZERO_LEN);
        end else begin
          emit(KIND_LENGTH, {25'd0, b}, '0, ERR_NONE);
          fb_left = b;
          phase   = PH_FLAGS;
        end
      end else if (!err_latched) begin
        case (phase)
          PH_FLAGS: begin
            emit(KIND_FLAGS, {25'd0, b}, '0, ERR_NONE);
            main_pend = b[4:0];
            fb_left   = fb_left - 8'd1;
            advance();
          end
          PH_PCR, PH_OPCR, PH_LTW, PH_RATE, PH_SEAMLESS: begin
            need = (phase == PH_LTW) ? NEED_LTW :
                   (phase == PH_RATE) ? NEED_RATE :
                   (phase == PH_SEAMLESS) ? NEED_SEAMLESS : NEED_PCR;
            shift    = {shift[39:0], b};
            elem_cnt = elem_cnt + 3'd1;
            fb_left  = fb_left - 8'd1;
            if (phase >= PH_LTW) ext_left = ext_left - 8'd1;
            if (elem_cnt >= need) finish_elem();
          end
          PH_SPLICE: begin
            emit(KIND_SPLICE, {25'd0, b}, '0, ERR_NONE);
            fb_left = fb_left - 8'd1;
            advance();
          end
          PH_PRIVLEN: begin
            if ({1'b0, fb_left} < 9'd1 + b) begin
              fail(ERR_PRIVATE);
            end else begin
              emit(KIND_PRIVLEN, {25'd0, b}, '0, ERR_NONE);
              fb_left = fb_left - 8'd1;
              skip    = b;
              if (b != 8'd0) phase = PH_PRIVSKIP;
              else advance();
            end
          end
          PH_PRIVSKIP: begin
            fb_left = fb_left - 8'd1;
            skip    = skip - 8'd1;
            if (skip == 8'd0) advance();
          end
          PH_EXTLEN: begin
            if (9'd1 + b > {1'b0, fb_left}) begin
              fail(ERR_EXT_LONG);
            end else begin
              emit(KIND_EXTLEN, {25'd0, b}, '0, ERR_NONE);
              fb_left = fb_left - 8'd1;
              if (b == 8'd0) begin
                fail(ERR_EXT_FLAGS);
              end else begin
                ext_left = b;
                phase    = PH_EXTFLAGS;
              end
            end
          end
          PH_EXTFLAGS: begin
            emit(KIND_EXTFLAGS, {25'd0, b}, '0, ERR_NONE);
            ext_pend = b[7:5];
            fb_left  = fb_left - 8'd1;
            ext_left = ext_left - 8'd1;
            advance();
          end
          PH_STUFF: begin
            fb_left = fb_left - 8'd1;
            if (fb_left == 8'd0) begin
              emit(KIND_END, '0, '0, ERR_NONE);
              phase = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      if (staged.size() > 0) begin
        r = staged.pop_back();
        r.last = 1'b1;
        staged.push_back(r);
      end
      foreach (staged[i]) expected_q.push_back(staged[i]);
    endfunction

    function void cmp_field(string name, logic [32:0] want, logic [32:0] got);
      if (got !== want) begin
        n_errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d main %0h",
                 $time, got.kind, got.main);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      kind_hits[want.kind]++;
      cmp_field("item_kind", want.kind, got.kind);
      cmp_field("main_value", want.main, got.main);
      cmp_field("extra_value", want.extra, got.extra);
      cmp_field("error_code", want.err, got.err);
      cmp_field("last_result", want.last, got.last);
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i      = 8'd0;
  logic        start_of_field_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [3:0]  item_kind_o;
  logic [32:0] main_value_o;
  logic [8:0]  extra_value_o;
  logic [3:0]  error_code_o;
  logic        last_result_o;

  field_scoreboard sb;
  logic [7:0]      field_q[$];
  int              ext_len_idx;
  int              priv_len_idx;
  int unsigned     burst_left = 1;
  rx_mode_e        rx_mode    = RX_ALWAYS;
  int unsigned     rx_run     = 0;
  int unsigned     rx_tick    = 0;
  int unsigned     drain;

  ts_adaptation_field_parser_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .start_of_field_i,
    .out_valid_o,
    .out_ready_i,
    .item_kind_o,
    .main_value_o,
    .extra_value_o,
    .error_code_o,
    .last_result_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver backpressure: modes chosen at random, each held for a random run.
  always @(negedge clk_i) begin
    if (rx_run == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_run  = $urandom_range(16, 200);
    end else begin
      rx_run--;
    end
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS:   out_ready_i <= 1'b1;
      RX_MOSTLY:   out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_RARELY:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= ((rx_tick % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin : result_monitor
    res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind  = kind_e'(item_kind_o);
      got.main  = main_value_o;
      got.extra = extra_value_o;
      got.err   = err_e'(error_code_o);
      got.last  = last_result_o;
      sb.check_result(got);
    end
  end

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    start_of_field_i <= sof;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, sof);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
        @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
  endtask

  task automatic run_directed();
    send_byte(8'h55, 1'b0);  // ignored before any start
    send_byte(8'h00, 1'b1);  // zero length
    send_byte(8'hAA, 1'b0);  // ignored after error
    send_byte(8'h02, 1'b1);
    send_byte(8'h04, 1'b0);
    send_byte(8'hFF, 1'b0);  // splice countdown then end
    send_byte(8'h01, 1'b1);
    send_byte(8'h10, 1'b0);  // pcr does not fit
    send_byte(8'h03, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h05, 1'b0);  // private data too long
    send_byte(8'h02, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);  // zero extension length
    send_byte(8'h03, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h03, 1'b0);  // extension too long
    send_byte(8'h05, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);  // stuffing, then restart mid-field
    send_byte(8'h01, 1'b1);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h12, 1'b0);  // ignored after end
  endtask

  task automatic make_field();
    logic [4:0] sel;
    logic [2:0] xsel;
    logic [7:0] r;
    int         plen;
    int         xstart;
    int         fstuff;
    field_q.delete();
    ext_len_idx  = -1;
    priv_len_idx = -1;
    sel  = 5'($urandom);
    xsel = 3'($urandom);
    r    = 8'($urandom);
    field_q.push_back(8'h00);
    field_q.push_back({r[7:5], sel});
    if (sel[4]) repeat (6) field_q.push_back(8'($urandom));
    if (sel[3]) repeat (6) field_q.push_back(8'($urandom));
    if (sel[2]) field_q.push_back(8'($urandom));
    if (sel[1]) begin
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 180) : $urandom_range(0, 6);
      priv_len_idx = field_q.size();
      field_q.push_back(8'(plen));
      repeat (plen) field_q.push_back(8'($urandom));
    end
    if (sel[0]) begin
      ext_len_idx = field_q.size();
      field_q.push_back(8'h00);
      xstart = field_q.size();
      r = 8'($urandom);
      field_q.push_back({xsel, r[4:0]});
      if (xsel[2]) repeat (2) field_q.push_back(8'($urandom));
      if (xsel[1]) repeat (3) field_q.push_back(8'($urandom));
      if (xsel[0]) repeat (5) field_q.push_back(8'($urandom));
      repeat ($urandom_range(0, 2)) field_q.push_back(8'($urandom));
      field_q[ext_len_idx] = 8'(field_q.size() - xstart);
    end
    fstuff = ($urandom_range(0, 29) == 0) ? 255 - (field_q.size() - 1) : $urandom_range(0, 3);
    repeat (fstuff) field_q.push_back(8'($urandom));
    field_q[0] = 8'(field_q.size() - 1);
  endtask

  task automatic damage_field();
    damage_e dmg;
    int      len;
    dmg = damage_e'($urandom_range(0, 4));
    len = field_q[0];
    case (dmg)
      DMG_SHORT_LEN: field_q[0] = 8'($urandom_range(0, len - 1));
      DMG_EXT_LEN: begin
        if (ext_len_idx >= 0)
          field_q[ext_len_idx] = 8'($urandom_range(0, 1) ?
                                 $urandom_range(0, field_q[ext_len_idx]) : $urandom_range(0, 255));
        else
          field_q[0] = 8'd0;
      end
      DMG_PRIV_LEN: begin
        if (priv_len_idx >= 0) field_q[priv_len_idx] = 8'($urandom);
        else field_q[0] = 8'($urandom_range(0, len));
      end
      DMG_LONG_LEN: field_q[0] = 8'((len + 5 > 255) ? 255 : len + $urandom_range(1, 5));
      default: repeat ($urandom_range(1, field_q.size() - 1)) void'(field_q.pop_back());
    endcase
  endtask

  task automatic run_random();
    int unsigned sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      make_field();
      if ($urandom_range(0, 3) == 0) damage_field();
      foreach (field_q[i]) send_byte(field_q[i], i == 0);
      sent += field_q.size();
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    drain = 0;
    while (sb.expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      sb.n_errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
    end
    $display("Run covered %0d input bytes in %0d started fields, %0d results checked",
             sb.n_bytes, sb.n_starts, sb.n_checked);
    $display("Result mix: pcr %0d, opcr %0d, ltw %0d, rate %0d, seamless %0d, end %0d, error %0d",
             sb.kind_hits[KIND_PCR], sb.kind_hits[KIND_OPCR], sb.kind_hits[KIND_LTW],
             sb.kind_hits[KIND_RATE], sb.kind_hits[KIND_SEAMLESS], sb.kind_hits[KIND_END],
             sb.kind_hits[KIND_ERROR]);
    if (sb.n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
